// File: rtl/iorc_pkg.sv
`default_nettype none

package iorc_pkg;

  // number of redirection entries and the index width that follows from it
  localparam int ENTRY_COUNT = 24;
  localparam int ENT_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  // stored bits of an entry low word (bits 16:0)
  localparam int LO_W = 17;

  // item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_PIN   = 2'd2;

  // bus offsets
  localparam logic [7:0] OFS_SELECT = 8'h00;
  localparam logic [7:0] OFS_WINDOW = 8'h10;
  localparam logic [7:0] OFS_EOI    = 8'h40;

  // window indices
  localparam logic [7:0] IDX_ID       = 8'h00;
  localparam logic [7:0] IDX_VERSION  = 8'h01;
  localparam logic [7:0] IDX_ARB      = 8'h02;
  localparam logic [7:0] IDX_ENT_BASE = 8'h10;

  // entry low word bit positions
  localparam int B_MASK    = 16;
  localparam int B_LEVEL   = 15;
  localparam int B_RIRR    = 14;
  localparam int B_ACTLOW  = 13;
  localparam int B_LOGICAL = 11;

  localparam logic [LO_W-1:0] LO_WRITABLE = 17'h1afff;
  localparam logic [LO_W-1:0] LO_RESET    = 17'h10000;
  localparam logic [7:0]      EOI_MIN_VER = 8'h20;
  localparam logic [7:0]      VER_RESET   = 8'h20;
  localparam logic [7:0]      MAX_ENTRY   = 8'(ENTRY_COUNT - 1);

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/iorc_ctrl.sv
`default_nettype none

module iorc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output iorc_pkg::cmd_t     cmd
);

  iorc_pkg::state_t state_r;
  iorc_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iorc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      iorc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = iorc_pkg::ST_EXEC;
        end
      end
      iorc_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = iorc_pkg::ST_OUT;
      end
      iorc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        if (!out_stall) begin
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = iorc_pkg::ST_EXEC;
          end else begin
            state_nxt = iorc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = iorc_pkg::ST_IDLE;
      end
    endcase
  end

  // a loaded beat is always executed next cycle
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("loaded beat not executed");

  // execution always presents a result
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("result not presented after execution");

  // never load while executing
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load during execution");

endmodule

`default_nettype wire

// File: rtl/iorc_datapath.sv
`default_nettype none

module iorc_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire iorc_pkg::cmd_t cmd,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic [1:0]    in_kind,
  input  wire logic [7:0]    in_reg_offset,
  input  wire logic [31:0]   in_write_data,
  input  wire logic [4:0]    in_pin_index,
  input  wire logic          in_pin_level,
  output logic [31:0]        out_read_data,
  output logic               out_msg_valid,
  output logic [7:0]         out_msg_vector,
  output logic [7:0]         out_msg_dest,
  output logic [2:0]         out_msg_delivery_mode,
  output logic               out_msg_dest_logical,
  output logic               out_msg_level_trig
);

  localparam int N = iorc_pkg::ENTRY_COUNT;
  localparam int EW = iorc_pkg::ENT_W;
  localparam int LW = iorc_pkg::LO_W;

  // latched input beat
  logic [1:0]  kind_r;
  logic [7:0]  ofs_r;
  logic [31:0] data_r;
  logic [4:0]  pin_r;
  logic        level_r;

  // architectural state
  logic [7:0]    version_r;
  logic [7:0]    sel_r;
  logic [3:0]    id_r;
  logic [LW-1:0] ent_lo_r   [N];
  logic [7:0]    ent_dest_r [N];
  logic          last_r     [N];

  // result registers
  logic [31:0] rd_r;
  logic        fire_r;
  logic [7:0]  vec_r;
  logic [7:0]  dest_r;
  logic [2:0]  mode_r;
  logic        logical_r;
  logic        trig_r;

  // decoded operation
  logic          is_read, is_write, is_pin;
  logic          wr_sel, wr_win, wr_eoi;
  logic [7:0]    win_off;
  logic [6:0]    win_ent7;
  logic          win_ok;
  logic [EW-1:0] win_ent;
  logic          win_wr_lo, win_wr_hi, win_wr_id;
  logic [LW-1:0] new_lo;
  logic          eoi_en;
  logic          pin_ok;
  logic [EW-1:0] pin_ent;
  logic [LW-1:0] pin_lo;
  logic [7:0]    pin_dest;
  logic          asserted;
  logic          fire;
  logic          set_rirr;
  logic [31:0]   rd;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      ofs_r   <= in_reg_offset;
      data_r  <= in_write_data;
      pin_r   <= in_pin_index;
      level_r <= in_pin_level;
    end
  end

  // version register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= iorc_pkg::VER_RESET;
    end else if (cfg_we) begin
      version_r <= cfg_wdata;
    end
  end

  // decode and result logic
  always_comb begin
    is_read  = (kind_r == iorc_pkg::KIND_READ);
    is_write = (kind_r == iorc_pkg::KIND_WRITE);
    is_pin   = (kind_r == iorc_pkg::KIND_PIN);
    wr_sel   = is_write && (ofs_r == iorc_pkg::OFS_SELECT);
    wr_win   = is_write && (ofs_r == iorc_pkg::OFS_WINDOW);
    wr_eoi   = is_write && (ofs_r == iorc_pkg::OFS_EOI);

    // window entry lookup
    win_off  = sel_r - iorc_pkg::IDX_ENT_BASE;
    win_ent7 = win_off[7:1];
    win_ok   = (sel_r >= iorc_pkg::IDX_ENT_BASE) && ({1'b0, win_ent7} < 8'(N));
    win_ent  = EW'(win_ent7);

    win_wr_id = wr_win && (sel_r == iorc_pkg::IDX_ID);
    win_wr_lo = wr_win && win_ok && !sel_r[0];
    win_wr_hi = wr_win && win_ok && sel_r[0];

    // remote-irr survives a low write only when level trigger stays selected
    new_lo = data_r[LW-1:0] & iorc_pkg::LO_WRITABLE;
    new_lo[iorc_pkg::B_RIRR] = data_r[iorc_pkg::B_LEVEL]
                               && ent_lo_r[win_ent][iorc_pkg::B_RIRR];

    eoi_en = wr_eoi && (version_r >= iorc_pkg::EOI_MIN_VER);

    // bus read data
    rd = 32'd0;
    if (is_read) begin
      if (ofs_r == iorc_pkg::OFS_SELECT) begin
        rd = {24'd0, sel_r};
      end else if (ofs_r == iorc_pkg::OFS_WINDOW) begin
        if (sel_r == iorc_pkg::IDX_ID || sel_r == iorc_pkg::IDX_ARB) begin
          rd = {4'd0, id_r, 24'd0};
        end else if (sel_r == iorc_pkg::IDX_VERSION) begin
          rd = {8'd0, iorc_pkg::MAX_ENTRY, 8'd0, version_r};
        end else if (win_ok) begin
          if (sel_r[0]) begin
            rd = {ent_dest_r[win_ent], 24'd0};
          end else begin
            rd = {{(32-LW){1'b0}}, ent_lo_r[win_ent]};
          end
        end
      end
    end

    // pin sample
    pin_ok   = is_pin && ({3'd0, pin_r} < 8'(N));
    pin_ent  = EW'(pin_r);
    pin_lo   = ent_lo_r[pin_ent];
    pin_dest = ent_dest_r[pin_ent];
    asserted = level_r ^ pin_lo[iorc_pkg::B_ACTLOW];
    fire     = 1'b0;
    set_rirr = 1'b0;
    if (pin_ok && asserted && !pin_lo[iorc_pkg::B_MASK]) begin
      if (pin_lo[iorc_pkg::B_LEVEL]) begin
        if (!pin_lo[iorc_pkg::B_RIRR]) begin
          fire     = 1'b1;
          set_rirr = 1'b1;
        end
      end else if (!last_r[pin_ent]) begin
        fire = 1'b1;
      end
    end
  end

  // select and id registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 8'd0;
      id_r  <= 4'd0;
    end else if (cmd.exec) begin
      if (wr_sel) begin
        sel_r <= data_r[7:0];
      end
      if (win_wr_id) begin
        id_r <= data_r[27:24];
      end
    end
  end

  // redirection entries and last assertion levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        ent_lo_r[i]   <= iorc_pkg::LO_RESET;
        ent_dest_r[i] <= 8'd0;
        last_r[i]     <= 1'b0;
      end
    end else if (cmd.exec) begin
      for (int i = 0; i < N; i++) begin
        if (eoi_en && ent_lo_r[i][iorc_pkg::B_LEVEL]
            && ent_lo_r[i][7:0] == data_r[7:0]) begin
          ent_lo_r[i][iorc_pkg::B_RIRR] <= 1'b0;
        end
        if (win_wr_lo && win_ent == EW'(i)) begin
          ent_lo_r[i] <= new_lo;
        end
        if (win_wr_hi && win_ent == EW'(i)) begin
          ent_dest_r[i] <= data_r[31:24];
        end
        if (pin_ok && pin_ent == EW'(i)) begin
          last_r[i] <= asserted;
          if (set_rirr) begin
            ent_lo_r[i][iorc_pkg::B_RIRR] <= 1'b1;
          end
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r      <= rd;
      fire_r    <= fire;
      vec_r     <= fire ? pin_lo[7:0] : 8'd0;
      dest_r    <= fire ? pin_dest : 8'd0;
      mode_r    <= fire ? pin_lo[10:8] : 3'd0;
      logical_r <= fire && pin_lo[iorc_pkg::B_LOGICAL];
      trig_r    <= fire && pin_lo[iorc_pkg::B_LEVEL];
    end
  end

  assign out_read_data         = rd_r;
  assign out_msg_valid         = fire_r;
  assign out_msg_vector        = vec_r;
  assign out_msg_dest          = dest_r;
  assign out_msg_delivery_mode = mode_r;
  assign out_msg_dest_logical  = logical_r;
  assign out_msg_level_trig    = trig_r;

endmodule

`default_nettype wire

// File: rtl/io_interrupt_redirection_controller.sv
// an accepted input beat is loaded, then executed into the result registers, and
// out_valid rises when the sequencer reaches its present state
// no new beat is taken while one executes, only in the idle or present state of the sequencer
// the next beat is taken in the same cycle the waiting result is taken
// reset (rst_n low, synchronous): select and id cleared, all entries masked,
// edge history cleared, version register back to 0x20, no result pending
`default_nettype none

module io_interrupt_redirection_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_reg_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [4:0]  in_pin_index,
  input  wire logic        in_pin_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_msg_valid,
  output logic [7:0]       out_msg_vector,
  output logic [7:0]       out_msg_dest,
  output logic [2:0]       out_msg_delivery_mode,
  output logic             out_msg_dest_logical,
  output logic             out_msg_level_trig
);

  iorc_pkg::cmd_t cmd;

  // sequencer
  iorc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // register file, entry table and delivery logic
  iorc_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_kind               (in_kind),
    .in_reg_offset         (in_reg_offset),
    .in_write_data         (in_write_data),
    .in_pin_index          (in_pin_index),
    .in_pin_level          (in_pin_level),
    .out_read_data         (out_read_data),
    .out_msg_valid         (out_msg_valid),
    .out_msg_vector        (out_msg_vector),
    .out_msg_dest          (out_msg_dest),
    .out_msg_delivery_mode (out_msg_delivery_mode),
    .out_msg_dest_logical  (out_msg_dest_logical),
    .out_msg_level_trig    (out_msg_level_trig)
  );

endmodule

`default_nettype wire

// File: dv/iorc_checker.sv
module iorc_checker
  import iorc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  input  logic [4:0]  in_pin_index,
  input  logic        in_pin_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_read_data,
  input  logic        out_msg_valid,
  input  logic [7:0]  out_msg_vector,
  input  logic [7:0]  out_msg_dest,
  input  logic [2:0]  out_msg_delivery_mode,
  input  logic        out_msg_dest_logical,
  input  logic        out_msg_level_trig,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // one reply beat: bus read data plus the delivery message
  typedef struct packed {
    logic [31:0] read_data;
    logic        msg_valid;
    logic [7:0]  vector;
    logic [7:0]  dest;
    logic [2:0]  mode;
    logic        logical;
    logic        level_trig;
  } reply_t;

  reply_t replies_due[$];

  // shadow of the controller state
  logic [7:0]      version;
  logic [7:0]      sel_idx;
  logic [3:0]      ctrl_id;
  logic [LO_W-1:0] lo_of[ENTRY_COUNT];
  logic [7:0]      dest_of[ENTRY_COUNT];
  logic            last_level[ENTRY_COUNT];

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    failures++;
  endtask

  // apply one input beat to the shadow state and work out its reply
  function automatic reply_t handle_item(input logic [1:0] kind, input logic [7:0] ofs,
                                         input logic [31:0] data, input logic [4:0] pin,
                                         input logic lvl);
    reply_t          r;
    logic [7:0]      ent;
    logic [LO_W-1:0] lo;
    logic            asserted;
    logic            was;
    r = '0;
    ent = (sel_idx - IDX_ENT_BASE) >> 1;
    case (kind)
      KIND_READ: begin
        if (ofs == OFS_SELECT) begin
          r.read_data = {24'b0, sel_idx};
        end else if (ofs == OFS_WINDOW) begin
          if (sel_idx == IDX_ID || sel_idx == IDX_ARB)
            r.read_data = {4'b0, ctrl_id, 24'b0};
          else if (sel_idx == IDX_VERSION)
            r.read_data = {8'b0, MAX_ENTRY, 8'b0, version};
          else if (sel_idx >= IDX_ENT_BASE && ent < ENTRY_COUNT)
            r.read_data = sel_idx[0] ? {dest_of[ent], 24'b0} : {15'b0, lo_of[ent]};
        end
      end
      KIND_WRITE: begin
        if (ofs == OFS_SELECT) begin
          sel_idx = data[7:0];
        end else if (ofs == OFS_WINDOW) begin
          if (sel_idx == IDX_ID) begin
            ctrl_id = data[27:24];
          end else if (sel_idx >= IDX_ENT_BASE && ent < ENTRY_COUNT) begin
            if (sel_idx[0]) begin
              dest_of[ent] = data[31:24];
            end else begin
              // remote-irr survives only while the entry stays level triggered
              lo = data[LO_W-1:0] & LO_WRITABLE;
              lo[B_RIRR] = lo_of[ent][B_RIRR] & data[B_LEVEL];
              lo_of[ent] = lo;
            end
          end
        end else if (ofs == OFS_EOI && version >= EOI_MIN_VER) begin
          for (int i = 0; i < ENTRY_COUNT; i++)
            if (lo_of[i][B_LEVEL] && lo_of[i][7:0] == data[7:0])
              lo_of[i][B_RIRR] = 1'b0;
        end
      end
      KIND_PIN: begin
        if (pin < ENTRY_COUNT) begin
          lo = lo_of[pin];
          asserted = lvl ^ lo[B_ACTLOW];
          was = last_level[pin];
          last_level[pin] = asserted;
          // level entries wait on remote-irr, edge entries on a rising assertion
          if (asserted && !lo[B_MASK] && (lo[B_LEVEL] ? !lo[B_RIRR] : !was)) begin
            r.msg_valid  = 1'b1;
            r.vector     = lo[7:0];
            r.dest       = dest_of[pin];
            r.mode       = lo[10:8];
            r.logical    = lo[B_LOGICAL];
            r.level_trig = lo[B_LEVEL];
            if (lo[B_LEVEL])
              lo_of[pin][B_RIRR] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // compare accepted replies first, then predict from the accepted input beat
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      version = VER_RESET;
      sel_idx = '0;
      ctrl_id = '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        lo_of[i]      = LO_RESET;
        dest_of[i]    = '0;
        last_level[i] = 1'b0;
      end
      replies_due.delete();
      failures = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.read_data  = out_read_data;
        got.msg_valid  = out_msg_valid;
        got.vector     = out_msg_vector;
        got.dest       = out_msg_dest;
        got.mode       = out_msg_delivery_mode;
        got.logical    = out_msg_dest_logical;
        got.level_trig = out_msg_level_trig;
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected reply beat", '0, got.read_data);
        end else begin
          want = replies_due.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, got.read_data);
          if (got.msg_valid !== want.msg_valid)
            report_mismatch("msg_valid", 32'(want.msg_valid), 32'(got.msg_valid));
          if (got.vector !== want.vector)
            report_mismatch("msg_vector", 32'(want.vector), 32'(got.vector));
          if (got.dest !== want.dest)
            report_mismatch("msg_dest", 32'(want.dest), 32'(got.dest));
          if (got.mode !== want.mode)
            report_mismatch("msg_delivery_mode", 32'(want.mode), 32'(got.mode));
          if (got.logical !== want.logical)
            report_mismatch("msg_dest_logical", 32'(want.logical), 32'(got.logical));
          if (got.level_trig !== want.level_trig)
            report_mismatch("msg_level_trig", 32'(want.level_trig),
                            32'(got.level_trig));
        end
      end
      if (cfg_we)
        version = cfg_wdata;
      if (in_valid && !in_stall)
        replies_due.push_back(handle_item(in_kind, in_reg_offset, in_write_data,
                                          in_pin_index, in_pin_level));
    end
    pending = replies_due.size();
  end

endmodule

// File: dv/testbench.sv
module testbench
  import iorc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam logic [7:0] OFS_UNUSED  = 8'h20;
  localparam int         PHASE_BEATS = 235;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_reg_offset = '0;
  logic [31:0] in_write_data = '0;
  logic [4:0]  in_pin_index = '0;
  logic        in_pin_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_msg_valid;
  logic [7:0]  out_msg_vector;
  logic [7:0]  out_msg_dest;
  logic [2:0]  out_msg_delivery_mode;
  logic        out_msg_dest_logical;
  logic        out_msg_level_trig;

  int fail_count;
  int pending;

  // idling rates and the long receiver hold-off
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int beats_sent = 0;

  // vector last programmed per entry, so that eoi beats hit something
  logic [7:0] vec_of[ENTRY_COUNT];

  io_interrupt_redirection_controller dut (.*);

  iorc_checker iorc_chk (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_kind, .in_reg_offset, .in_write_data,
    .in_pin_index, .in_pin_level,
    .out_valid, .out_stall, .out_read_data, .out_msg_valid, .out_msg_vector,
    .out_msg_dest, .out_msg_delivery_mode, .out_msg_dest_logical, .out_msg_level_trig,
    .failures(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 60;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // offer one input beat and wait until it is taken
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] ofs,
                           input logic [31:0] data, input logic [4:0] pin, input logic lvl);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_reg_offset <= ofs;
    in_write_data <= data;
    in_pin_index  <= pin;
    in_pin_level  <= lvl;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    beats_sent++;
  endtask

  task automatic bus_read(input logic [7:0] ofs);
    send_beat(KIND_READ, ofs, $urandom, 5'($urandom), 1'($urandom));
  endtask

  task automatic bus_write(input logic [7:0] ofs, input logic [31:0] data);
    send_beat(KIND_WRITE, ofs, data, 5'($urandom), 1'($urandom));
  endtask

  task automatic window_write(input logic [7:0] idx, input logic [31:0] data);
    bus_write(OFS_SELECT, {24'($urandom), idx});
    bus_write(OFS_WINDOW, data);
  endtask

  task automatic sample_pin(input logic [4:0] pin, input logic lvl);
    send_beat(KIND_PIN, 8'($urandom), $urandom, pin, lvl);
  endtask

  // stop offering until every reply is back, then let the pipe settle
  task automatic wait_all_delivered();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random burst: mostly programming and firing entries, some noise
  task automatic random_sequence();
    int          r;
    int          p;
    logic [31:0] lo_word;
    logic [7:0]  idx;
    r = $urandom_range(99);
    p = $urandom_range(ENTRY_COUNT - 1);
    if (r < 30) begin
      // program an entry, usually unmasked, vectors shared for eoi hits
      lo_word = $urandom;
      lo_word[B_MASK] = ($urandom_range(9) < 2);
      lo_word[7:0] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(8'h30 + $urandom_range(3));
      vec_of[p] = lo_word[7:0];
      window_write(8'(IDX_ENT_BASE + 2 * p), lo_word);
      if ($urandom_range(1))
        window_write(8'(IDX_ENT_BASE + 2 * p + 1), $urandom);
      if ($urandom_range(3) == 0)
        bus_read(OFS_WINDOW);
    end else if (r < 62) begin
      // a few samples on one pin, now and then out of range
      if ($urandom_range(15) == 0)
        p = $urandom_range(ENTRY_COUNT, 31);
      repeat ($urandom_range(1, 4))
        sample_pin(5'(p), 1'($urandom));
    end else if (r < 72) begin
      bus_write(OFS_EOI, {24'($urandom),
                          ($urandom_range(3) == 0) ? 8'($urandom) : vec_of[p]});
    end else if (r < 86) begin
      // poke a window register: id, version, arbitration or anything
      case ($urandom_range(3))
        0: idx = IDX_ID;
        1: idx = IDX_VERSION;
        2: idx = IDX_ARB;
        default: idx = 8'($urandom);
      endcase
      bus_write(OFS_SELECT, {24'($urandom), idx});
      bus_read(OFS_WINDOW);
      bus_write(OFS_WINDOW, $urandom);
      bus_read(($urandom_range(1)) ? OFS_WINDOW : OFS_SELECT);
    end else if (r < 96) begin
      send_beat(2'($urandom), 8'($urandom), $urandom, 5'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(2))
        0: bus_read(OFS_SELECT);
        1: bus_read(OFS_EOI);
        default: bus_read(8'($urandom));
      endcase
    end
    if ($urandom_range(79) == 0)
      wait_all_delivered();
  endtask

  initial begin
    logic [7:0] version_plan[4];
    int         tx_plan[4];
    int         rx_plan[4];
    int         phase_start;
    version_plan = '{8'h00, 8'hff, 8'h1f, 8'h20};
    tx_plan      = '{26, 88, 0, 0};
    rx_plan      = '{88, 26, 0, 0};
    for (int i = 0; i < ENTRY_COUNT; i++)
      vec_of[i] = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: id, version, select width, level and edge firing, eoi, odd cases
    bus_read(OFS_SELECT);
    bus_read(OFS_WINDOW);
    bus_write(OFS_WINDOW, '1);
    bus_read(OFS_WINDOW);
    bus_write(OFS_SELECT, {24'hffffff, IDX_VERSION});
    bus_read(OFS_WINDOW);
    window_write(8'(IDX_ENT_BASE + 1), '1);
    // entry 0: level, fixed mode 7, logical, vector 0x33
    window_write(IDX_ENT_BASE, 32'h0000_8f33);
    sample_pin(5'd0, 1'b1);
    sample_pin(5'd0, 1'b1);
    bus_read(OFS_WINDOW);
    bus_write(OFS_EOI, 32'hffff_ff33);
    sample_pin(5'd0, 1'b1);
    // window index past the last entry
    window_write(8'(IDX_ENT_BASE + 2 * ENTRY_COUNT), '1);
    bus_read(OFS_WINDOW);
    sample_pin(5'(ENTRY_COUNT), 1'b1);
    send_beat(KIND_NONE, '1, '1, '1, 1'b1);
    bus_read(OFS_EOI);
    bus_write(OFS_UNUSED, '1);
    // entry 1: edge, active low, vector 0x41
    window_write(8'(IDX_ENT_BASE + 2), 32'h0000_2041);
    sample_pin(5'd1, 1'b0);
    sample_pin(5'd1, 1'b0);
    sample_pin(5'd1, 1'b1);
    sample_pin(5'd1, 1'b0);

    // random phases, each with its own version setting and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      wait_all_delivered();
      write_version(version_plan[ph]);
      @(posedge clk);
      tx_idle_pct = tx_plan[ph];
      rx_idle_pct = rx_plan[ph];
      if (ph == 2)
        hold_req = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS)
        random_sequence();
    end

    wait_all_delivered();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
